FILE: rtl/core/tps_pkg.sv
// Shared types and codes for the tick-driven priority task scheduler.
// Used by tps_ctrl, tps_dp and tick_priority_task_scheduler; no dependencies.
`default_nettype none

package tps_pkg;

    typedef enum logic [2:0] {
        CMD_ADD         = 3'd0,
        CMD_START       = 3'd1,
        CMD_TICK        = 3'd2,
        CMD_YIELD       = 3'd3,
        CMD_SLEEP       = 3'd4,
        CMD_SLEEP_UNTIL = 3'd5,
        CMD_KILL        = 3'd6,
        CMD_QUERY       = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        SS_EMPTY = 2'd0,
        SS_READY = 2'd1,
        SS_SLEEP = 2'd2
    } slot_state_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  priority_req;
        logic [31:0] stack_pointer;
        logic [31:0] delay;
        logic [31:0] reference;
    } in_t;

    typedef struct packed {
        logic [3:0]  running_task;
        logic [31:0] next_stack;
        logic [31:0] tick_now;
        logic [31:0] new_reference;
        logic        slot_empty;
        logic        error;
    } out_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_EXEC,
        CS_TICK,
        CS_YIELD,
        CS_STACK_RD,
        CS_RESULT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_EXEC,
        DP_TICK_EVAL,
        DP_YIELD_STEP,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic go_tick;
        logic go_yield;
        logic tick_last;
        logic yield_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/tps_ctrl.sv
// Sequencer for the task scheduler: walks each transaction through exec,
// tick scan or yield walk, stack read and result load. Uses tps_pkg.
`default_nettype none

module tps_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire tps_pkg::dp_status_t status,
    output tps_pkg::dp_cmd_t      cmd
);

    tps_pkg::ctrl_state_t state_reg;
    tps_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tps_pkg::CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd.op     = tps_pkg::DP_NOP;
        case (state_reg)
            tps_pkg::CS_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = tps_pkg::DP_CAPTURE;
                    state_next = tps_pkg::CS_EXEC;
                end
            end
            tps_pkg::CS_EXEC: begin
                cmd.op = tps_pkg::DP_EXEC;
                if (status.go_tick) begin
                    state_next = tps_pkg::CS_TICK;
                end else if (status.go_yield) begin
                    state_next = tps_pkg::CS_YIELD;
                end else begin
                    state_next = tps_pkg::CS_STACK_RD;
                end
            end
            tps_pkg::CS_TICK: begin
                cmd.op = tps_pkg::DP_TICK_EVAL;
                if (status.tick_last) begin
                    state_next = tps_pkg::CS_STACK_RD;
                end
            end
            tps_pkg::CS_YIELD: begin
                cmd.op = tps_pkg::DP_YIELD_STEP;
                if (status.yield_last) begin
                    state_next = tps_pkg::CS_STACK_RD;
                end
            end
            tps_pkg::CS_STACK_RD: begin
                // stack RAM output settles on the final current slot
                state_next = tps_pkg::CS_RESULT;
            end
            tps_pkg::CS_RESULT: begin
                if (status.out_free) begin
                    cmd.op     = tps_pkg::DP_RESULT;
                    state_next = tps_pkg::CS_IDLE;
                end
            end
            default: begin
                state_next = tps_pkg::CS_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/tps_dp.sv
// Scheduler datapath: slot states, wake-tick and saved-stack RAMs, tick counter,
// current slot and the result register. Driven by tps_ctrl; uses tps_pkg.
`default_nettype none

module tps_dp #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    input  wire logic [31:0]        cfg_data,
    input  wire tps_pkg::in_t       s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output tps_pkg::out_t           m_data,
    input  wire tps_pkg::dp_cmd_t   cmd,
    output tps_pkg::dp_status_t     status
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam logic [IW-1:0] IDLE_SLOT = IW'(SLOT_COUNT - 1);

    tps_pkg::in_t        item_reg;
    logic [IW-1:0]       cur_reg;
    logic [31:0]         tick_reg;
    logic                running_reg;
    logic [31:0]         idle_init_reg;
    tps_pkg::slot_state_t slot_state_reg [SLOT_COUNT];
    logic [IW-1:0]       eval_idx_reg;
    logic                err_reg;
    logic                empty_reg;
    logic [31:0]         newref_reg;
    tps_pkg::out_t       out_reg;
    logic                m_valid_reg;
    logic [SLOT_COUNT-1:0] sv_valid_reg;

    logic [31:0]         stack_mem [SLOT_COUNT];
    logic [31:0]         stack_rd_reg;
    logic                stack_rd_valid_reg;
    logic [31:0]         wake_mem [SLOT_COUNT];
    logic [31:0]         wake_rd_reg;

    // decode
    logic                prio_ok;
    logic [IW-1:0]       prio_idx;
    logic                at_idle;
    logic [IW-1:0]       cur_inc;
    logic [IW-1:0]       st_ra;
    tps_pkg::slot_state_t st_rd;
    logic [31:0]         tick_inc;
    logic [31:0]         since_ref;
    logic [31:0]         ref_plus;
    logic [31:0]         tick_plus;
    logic                woke;

    // actions
    logic                st_we;
    logic [IW-1:0]       st_wa;
    tps_pkg::slot_state_t st_wd;
    logic                sk_we;
    logic [IW-1:0]       sk_wa;
    logic [31:0]         sk_wd;
    logic                wk_we;
    logic [31:0]         wk_wd;
    logic [IW-1:0]       wk_ra;
    logic                e_err;
    logic                e_empty;
    logic [31:0]         e_newref;
    logic                e_tick;
    logic                e_yield;
    logic                e_start;
    logic                eval_ready;

    assign prio_ok  = 32'(item_reg.priority_req) < 32'(SLOT_COUNT);
    assign prio_idx = prio_ok ? IW'(item_reg.priority_req) : '0;
    assign at_idle  = (cur_reg == IDLE_SLOT);
    assign cur_inc  = at_idle ? cur_reg : cur_reg + 1'b1;
    assign tick_inc  = tick_reg + 32'd1;
    assign since_ref = tick_reg - item_reg.reference;
    assign ref_plus  = item_reg.reference + item_reg.delay;
    assign tick_plus = tick_reg + item_reg.delay;

    always_comb begin
        st_ra = cur_reg;
        case (cmd.op)
            tps_pkg::DP_EXEC: begin
                if (item_reg.command == tps_pkg::CMD_ADD ||
                    item_reg.command == tps_pkg::CMD_QUERY) begin
                    st_ra = prio_idx;
                end
            end
            tps_pkg::DP_TICK_EVAL:  st_ra = eval_idx_reg;
            tps_pkg::DP_YIELD_STEP: st_ra = cur_inc;
            default:                st_ra = cur_reg;
        endcase
    end

    assign st_rd      = slot_state_reg[st_ra];
    assign woke       = (st_rd == tps_pkg::SS_SLEEP) && (wake_rd_reg == tick_reg);
    assign eval_ready = woke || (st_rd == tps_pkg::SS_READY);
    assign wk_ra      = (cmd.op == tps_pkg::DP_EXEC) ? IDLE_SLOT : eval_idx_reg - 1'b1;

    always_comb begin
        st_we    = 1'b0;
        st_wa    = cur_reg;
        st_wd    = tps_pkg::SS_READY;
        sk_we    = 1'b0;
        sk_wa    = cur_reg;
        sk_wd    = item_reg.stack_pointer;
        wk_we    = 1'b0;
        wk_wd    = tick_plus;
        e_err    = 1'b0;
        e_empty  = 1'b0;
        e_newref = 32'd0;
        e_tick   = 1'b0;
        e_yield  = 1'b0;
        e_start  = 1'b0;
        if (cmd.op == tps_pkg::DP_EXEC) begin
            case (tps_pkg::cmd_t'(item_reg.command))
                tps_pkg::CMD_ADD: begin
                    if (!prio_ok || st_rd != tps_pkg::SS_EMPTY) begin
                        e_err = 1'b1;
                    end else begin
                        sk_we = 1'b1;
                        sk_wa = prio_idx;
                        st_we = 1'b1;
                        st_wa = prio_idx;
                        st_wd = tps_pkg::SS_READY;
                    end
                end
                tps_pkg::CMD_START: begin
                    if (running_reg) begin
                        e_err = 1'b1;
                    end else begin
                        e_start = 1'b1;
                        sk_we   = 1'b1;
                        sk_wa   = IDLE_SLOT;
                        sk_wd   = idle_init_reg;
                    end
                end
                tps_pkg::CMD_TICK: begin
                    if (!running_reg) begin
                        e_err = 1'b1;
                    end else begin
                        sk_we  = 1'b1;
                        e_tick = 1'b1;
                    end
                end
                tps_pkg::CMD_YIELD: begin
                    if (!running_reg) begin
                        e_err = 1'b1;
                    end else begin
                        sk_we   = 1'b1;
                        e_yield = 1'b1;
                    end
                end
                tps_pkg::CMD_SLEEP: begin
                    if (!running_reg || at_idle) begin
                        e_err = 1'b1;
                    end else begin
                        sk_we   = 1'b1;
                        e_yield = 1'b1;
                        if (item_reg.delay != 32'd0) begin
                            wk_we = 1'b1;
                            wk_wd = tick_plus;
                            st_we = 1'b1;
                            st_wd = tps_pkg::SS_SLEEP;
                        end
                    end
                end
                tps_pkg::CMD_SLEEP_UNTIL: begin
                    if (!running_reg || at_idle || item_reg.delay == 32'd0) begin
                        e_err    = 1'b1;
                        e_newref = item_reg.reference;
                    end else begin
                        sk_we   = 1'b1;
                        e_yield = 1'b1;
                        if (since_ref < item_reg.delay) begin
                            e_newref = ref_plus;
                            wk_we    = 1'b1;
                            wk_wd    = ref_plus;
                            st_we    = 1'b1;
                            st_wd    = tps_pkg::SS_SLEEP;
                        end else begin
                            // period already missed: no sleep
                            e_newref = tick_reg;
                        end
                    end
                end
                tps_pkg::CMD_KILL: begin
                    if (!running_reg || at_idle) begin
                        e_err = 1'b1;
                    end else begin
                        sk_we   = 1'b1;
                        e_yield = 1'b1;
                        st_we   = 1'b1;
                        st_wd   = tps_pkg::SS_EMPTY;
                    end
                end
                tps_pkg::CMD_QUERY: begin
                    if (!prio_ok) begin
                        e_empty = 1'b1;
                        e_err   = 1'b1;
                    end else begin
                        e_empty = (st_rd == tps_pkg::SS_EMPTY);
                    end
                end
                default: begin
                    e_err = 1'b1;
                end
            endcase
        end else if (cmd.op == tps_pkg::DP_TICK_EVAL) begin
            if (woke) begin
                st_we = 1'b1;
                st_wa = eval_idx_reg;
                st_wd = tps_pkg::SS_READY;
            end
        end
    end

    assign status.go_tick    = e_tick;
    assign status.go_yield   = e_yield;
    assign status.tick_last  = (eval_idx_reg == '0);
    assign status.yield_last = at_idle || (cur_inc == IDLE_SLOT) ||
                               (st_rd == tps_pkg::SS_READY);
    assign status.out_free   = !m_valid_reg || m_ready;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg       <= IDLE_SLOT;
            tick_reg      <= 32'd0;
            running_reg   <= 1'b0;
            idle_init_reg <= 32'd0;
            m_valid_reg   <= 1'b0;
            sv_valid_reg  <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_state_reg[i] <= (i == SLOT_COUNT - 1) ? tps_pkg::SS_READY
                                                          : tps_pkg::SS_EMPTY;
            end
        end else begin
            if (cfg_valid) begin
                idle_init_reg <= cfg_data;
            end
            if (st_we) begin
                slot_state_reg[st_wa] <= st_wd;
            end
            if (sk_we) begin
                sv_valid_reg[sk_wa] <= 1'b1;
            end
            if (e_start) begin
                running_reg <= 1'b1;
                cur_reg     <= IDLE_SLOT;
            end
            if (e_tick) begin
                tick_reg <= tick_inc;
            end
            // descending scan: last ready slot seen is the highest priority
            if (cmd.op == tps_pkg::DP_TICK_EVAL && eval_ready) begin
                cur_reg <= eval_idx_reg;
            end
            if (cmd.op == tps_pkg::DP_YIELD_STEP) begin
                cur_reg <= cur_inc;
            end
            if (cmd.op == tps_pkg::DP_RESULT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.op == tps_pkg::DP_CAPTURE) begin
            item_reg <= s_data;
        end
        if (cmd.op == tps_pkg::DP_EXEC) begin
            err_reg      <= e_err;
            empty_reg    <= e_empty;
            newref_reg   <= e_newref;
            eval_idx_reg <= IDLE_SLOT;
        end else if (cmd.op == tps_pkg::DP_TICK_EVAL) begin
            eval_idx_reg <= eval_idx_reg - 1'b1;
        end
        if (cmd.op == tps_pkg::DP_RESULT) begin
            out_reg.running_task  <= 4'(cur_reg);
            out_reg.next_stack    <= stack_rd_valid_reg ? stack_rd_reg : 32'd0;
            out_reg.tick_now      <= tick_reg;
            out_reg.new_reference <= newref_reg;
            out_reg.slot_empty    <= empty_reg;
            out_reg.error         <= err_reg;
        end
    end

    // saved-stack RAM, read port follows the current slot
    always_ff @(posedge aclk) begin
        if (sk_we) begin
            stack_mem[sk_wa] <= sk_wd;
        end
        stack_rd_reg       <= stack_mem[cur_reg];
        stack_rd_valid_reg <= sv_valid_reg[cur_reg];
    end

    // wake-tick RAM, read one slot ahead of the tick scan
    always_ff @(posedge aclk) begin
        if (wk_we) begin
            wake_mem[cur_reg] <= wk_wd;
        end
        wake_rd_reg <= wake_mem[wk_ra];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/tick_priority_task_scheduler.sv
// Tick-driven fixed-priority task scheduler, top level (tps_ctrl + tps_dp).
// Add, start, query and any rejected command go from exec straight to the stack
// read; tick scans every slot, one slot per cycle through the wake-tick RAM;
// yield, sleep, sleep-until and kill walk from the current slot towards idle.
// One transaction at a time; the next is accepted in the cycle after the result
// is loaded. Synchronous active-low reset; no clearing pass is needed.
`default_nettype none

module tick_priority_task_scheduler #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [31:0]   cfg_data,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire tps_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output tps_pkg::out_t      m_data
);

    tps_pkg::dp_cmd_t    dp_cmd;
    tps_pkg::dp_status_t dp_status;
    logic                cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    tps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (dp_status),
        .cmd     (dp_cmd)
    );

    tps_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_wr),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

endmodule

`default_nettype wire

FILE: bench/tick_priority_task_scheduler_tb.sv
// Self-checking bench for tick_priority_task_scheduler: scheduler commands in, decisions out.
// Predicts each decision in a small scoreboard class; depends only on tps_pkg and the DUT.
`timescale 1ns / 100ps

module tick_priority_task_scheduler_tb;

    localparam int SLOTS       = 16;
    localparam int IDLE        = SLOTS - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 335;

    class sched_scoreboard;
        tps_pkg::slot_state_t slot_st[SLOTS];
        logic [31:0] wake_at[SLOTS];
        logic [31:0] stack_of[SLOTS];
        int unsigned cur_slot;
        logic [31:0] ticks;
        bit          started;
        logic [31:0] boot_sp;
        tps_pkg::out_t sched_decisions_q[$];
        int unsigned mismatches;
        int unsigned decisions_seen;
        int unsigned rejected;
        int unsigned cmd_count[8];

        function new();
            foreach (slot_st[i]) begin
                slot_st[i]  = tps_pkg::SS_EMPTY;
                wake_at[i]  = '0;
                stack_of[i] = '0;
            end
            foreach (cmd_count[i]) cmd_count[i] = 0;
            slot_st[IDLE] = tps_pkg::SS_READY;
            cur_slot = IDLE;
            ticks = '0;
            started = 1'b0;
            boot_sp = '0;
            mismatches = 0;
            decisions_seen = 0;
            rejected = 0;
        endfunction

        function void set_boot_sp(logic [31:0] v);
            boot_sp = v;
        endfunction

        function int pending();
            return sched_decisions_q.size();
        endfunction

        // move down to the next ready slot, idle as the floor
        function void yield_from(logic [31:0] sp);
            stack_of[cur_slot] = sp;
            if (cur_slot >= IDLE) return;
            do cur_slot++; while (cur_slot < IDLE && slot_st[cur_slot] != tps_pkg::SS_READY);
        endfunction

        // wake matching sleepers, pick the lowest ready slot number
        function void tick_from(logic [31:0] sp);
            int n;
            stack_of[cur_slot] = sp;
            ticks = ticks + 32'd1;
            for (n = SLOTS - 1; n >= 0; n--) begin
                if (slot_st[n] == tps_pkg::SS_SLEEP && wake_at[n] == ticks)
                    slot_st[n] = tps_pkg::SS_READY;
                if (slot_st[n] == tps_pkg::SS_READY) cur_slot = n;
            end
        endfunction

        function void apply_command(tps_pkg::in_t it);
            tps_pkg::out_t d;
            bit          at_idle;
            logic [31:0] nref;
            logic [31:0] since;
            bit          emp;
            bit          err;
            at_idle = (cur_slot >= IDLE);
            nref = '0;
            emp = 1'b0;
            err = 1'b0;
            cmd_count[it.command]++;
            case (it.command)
                tps_pkg::CMD_ADD: begin
                    if (int'(it.priority_req) >= SLOTS ||
                        slot_st[it.priority_req] != tps_pkg::SS_EMPTY) begin
                        err = 1'b1;
                    end else begin
                        stack_of[it.priority_req] = it.stack_pointer;
                        slot_st[it.priority_req]  = tps_pkg::SS_READY;
                    end
                end
                tps_pkg::CMD_START: begin
                    if (started) begin
                        err = 1'b1;
                    end else begin
                        started = 1'b1;
                        cur_slot = IDLE;
                        stack_of[IDLE] = boot_sp;
                    end
                end
                tps_pkg::CMD_TICK: begin
                    if (!started) err = 1'b1;
                    else tick_from(it.stack_pointer);
                end
                tps_pkg::CMD_YIELD: begin
                    if (!started) err = 1'b1;
                    else yield_from(it.stack_pointer);
                end
                tps_pkg::CMD_SLEEP: begin
                    if (!started || at_idle) begin
                        err = 1'b1;
                    end else begin
                        if (it.delay != 0) begin
                            wake_at[cur_slot] = ticks + it.delay;
                            slot_st[cur_slot] = tps_pkg::SS_SLEEP;
                        end
                        yield_from(it.stack_pointer);
                    end
                end
                tps_pkg::CMD_SLEEP_UNTIL: begin
                    if (!started || at_idle || it.delay == 0) begin
                        err = 1'b1;
                        nref = it.reference;
                    end else begin
                        since = ticks - it.reference;
                        if (since < it.delay) begin
                            nref = it.reference + it.delay;
                            wake_at[cur_slot] = nref;
                            slot_st[cur_slot] = tps_pkg::SS_SLEEP;
                        end else begin
                            // period already missed: report now, no sleep
                            nref = ticks;
                        end
                        yield_from(it.stack_pointer);
                    end
                end
                tps_pkg::CMD_KILL: begin
                    if (!started || at_idle) begin
                        err = 1'b1;
                    end else begin
                        slot_st[cur_slot] = tps_pkg::SS_EMPTY;
                        yield_from(it.stack_pointer);
                    end
                end
                default: begin
                    if (int'(it.priority_req) >= SLOTS) begin
                        emp = 1'b1;
                        err = 1'b1;
                    end else begin
                        emp = (slot_st[it.priority_req] == tps_pkg::SS_EMPTY);
                    end
                end
            endcase
            if (err) rejected++;
            d.running_task  = 4'(cur_slot);
            d.next_stack    = stack_of[cur_slot];
            d.tick_now      = ticks;
            d.new_reference = nref;
            d.slot_empty    = emp;
            d.error         = err;
            sched_decisions_q.push_back(d);
        endfunction

        function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_result(tps_pkg::out_t got);
            tps_pkg::out_t want;
            decisions_seen++;
            if (sched_decisions_q.size() == 0) begin
                $error("result transaction with nothing outstanding: 0x%h", got);
                mismatches++;
                return;
            end
            want = sched_decisions_q.pop_front();
            check_field("running_task", 32'(want.running_task), 32'(got.running_task));
            check_field("next_stack", want.next_stack, got.next_stack);
            check_field("tick_now", want.tick_now, got.tick_now);
            check_field("new_reference", want.new_reference, got.new_reference);
            check_field("slot_empty", 32'(want.slot_empty), 32'(got.slot_empty));
            check_field("error", 32'(want.error), 32'(got.error));
        endfunction
    endclass

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [31:0]   cfg_data;
    logic          s_valid;
    logic          s_ready;
    tps_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    tps_pkg::out_t m_data;

    sched_scoreboard sb;
    bit              no_idle;
    int unsigned     cycle_count;
    int unsigned     cfg_writes;

    tick_priority_task_scheduler #(
        .SLOT_COUNT(SLOTS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic tps_pkg::in_t mk(tps_pkg::cmd_t c, logic [3:0] p, logic [31:0] sp,
                                        logic [31:0] dly, logic [31:0] rf);
        tps_pkg::in_t it;
        it.command       = c;
        it.priority_req  = p;
        it.stack_pointer = sp;
        it.delay         = dly;
        it.reference     = rf;
        return it;
    endfunction

    // mostly well-formed sleeps near the current tick so tasks keep waking
    function automatic tps_pkg::in_t random_item();
        tps_pkg::in_t it;
        int          pick;
        int          sub;
        logic [31:0] t;
        t = sb.ticks;
        it = mk(tps_pkg::CMD_QUERY, 4'($urandom_range(0, 15)), $urandom(), $urandom(),
                $urandom());
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            it.command = tps_pkg::CMD_ADD;
        end else if (pick < 46) begin
            it.command = tps_pkg::CMD_TICK;
        end else if (pick < 60) begin
            it.command = tps_pkg::CMD_YIELD;
        end else if (pick < 72) begin
            it.command = tps_pkg::CMD_SLEEP;
            sub = $urandom_range(0, 49);
            if (sub == 0) it.delay = '0;
            else if (sub < 49) it.delay = $urandom_range(1, 10);
        end else if (pick < 86) begin
            it.command = tps_pkg::CMD_SLEEP_UNTIL;
            sub = $urandom_range(0, 19);
            if (sub < 13) begin
                it.delay = $urandom_range(1, 12);
                it.reference = t - 32'($urandom_range(0, int'(it.delay) + 3));
            end else if (sub < 16) begin
                it.reference = t - it.delay - 32'($urandom_range(0, 50));
            end else if (sub < 18) begin
                it.delay = '0;
            end
        end else if (pick < 92) begin
            it.command = tps_pkg::CMD_KILL;
        end else if (pick < 99) begin
            it.command = tps_pkg::CMD_QUERY;
        end else begin
            it.command = tps_pkg::CMD_START;
        end
        return it;
    endfunction

    task automatic send_item(input tps_pkg::in_t it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.apply_command(it);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_boot_sp(v);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic collect_results();
        int stall;
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_data);
        end
    endtask

    initial begin
        sb = new();
        no_idle = 1'b0;
        cfg_writes = 0;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        m_ready   <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            collect_results();
        join_none
        @(posedge aclk);

        // before start: slot bookkeeping and every not-running rejection
        write_cfg(32'hFFFF_FFFF);
        send_item(mk(tps_pkg::CMD_QUERY, 4'd0, $urandom(), $urandom(), $urandom()));
        send_item(mk(tps_pkg::CMD_QUERY, 4'd15, $urandom(), $urandom(), $urandom()));
        send_item(mk(tps_pkg::CMD_ADD, 4'd15, 32'h1234_5678, '0, '0));
        send_item(mk(tps_pkg::CMD_ADD, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(mk(tps_pkg::CMD_ADD, 4'd0, 32'h0, '0, '0));
        send_item(mk(tps_pkg::CMD_TICK, 4'd0, $urandom(), $urandom(), $urandom()));
        send_item(mk(tps_pkg::CMD_YIELD, 4'd0, $urandom(), $urandom(), $urandom()));
        send_item(mk(tps_pkg::CMD_SLEEP, 4'd0, $urandom(), 32'd5, $urandom()));
        send_item(mk(tps_pkg::CMD_SLEEP_UNTIL, 4'd0, $urandom(), 32'd7, 32'hFFFF_FFFF));
        send_item(mk(tps_pkg::CMD_KILL, 4'd0, $urandom(), $urandom(), $urandom()));
        drain();
        write_cfg(32'h0);
        write_cfg($urandom());

        // running: idle restrictions, selection, sleeps, missed period, kill
        send_item(mk(tps_pkg::CMD_START, 4'd3, $urandom(), $urandom(), $urandom()));
        send_item(mk(tps_pkg::CMD_START, 4'd3, $urandom(), $urandom(), $urandom()));
        send_item(mk(tps_pkg::CMD_SLEEP, 4'd0, $urandom(), 32'd3, $urandom()));
        send_item(mk(tps_pkg::CMD_KILL, 4'd0, $urandom(), $urandom(), $urandom()));
        send_item(mk(tps_pkg::CMD_YIELD, 4'd0, 32'h1234_5678, $urandom(), $urandom()));
        send_item(mk(tps_pkg::CMD_TICK, 4'd0, 32'h0, $urandom(), $urandom()));
        send_item(mk(tps_pkg::CMD_SLEEP, 4'd0, $urandom(), 32'd0, $urandom()));
        send_item(mk(tps_pkg::CMD_ADD, 4'd7, 32'h0000_7777, $urandom(), $urandom()));
        send_item(mk(tps_pkg::CMD_TICK, 4'd0, $urandom(), $urandom(), $urandom()));
        send_item(mk(tps_pkg::CMD_SLEEP_UNTIL, 4'd0, $urandom(), 32'd0, $urandom()));
        send_item(mk(tps_pkg::CMD_SLEEP_UNTIL, 4'd0, $urandom(), 32'd3, sb.ticks - 32'd5));
        send_item(mk(tps_pkg::CMD_YIELD, 4'd0, $urandom(), $urandom(), $urandom()));
        send_item(mk(tps_pkg::CMD_TICK, 4'd0, $urandom(), $urandom(), $urandom()));
        send_item(mk(tps_pkg::CMD_SLEEP_UNTIL, 4'd0, $urandom(), 32'd2, sb.ticks));
        send_item(mk(tps_pkg::CMD_KILL, 4'd0, $urandom(), $urandom(), $urandom()));
        send_item(mk(tps_pkg::CMD_QUERY, 4'd7, $urandom(), $urandom(), $urandom()));
        send_item(mk(tps_pkg::CMD_TICK, 4'd0, $urandom(), $urandom(), $urandom()));
        send_item(mk(tps_pkg::CMD_TICK, 4'd0, $urandom(), $urandom(), $urandom()));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            no_idle = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
            drain();
            if (ph == 0) write_cfg(32'h0);
            else if (ph == 1) write_cfg(32'hFFFF_FFFF);
            else write_cfg($urandom());
        end

        repeat (SLOTS + 8) @(posedge aclk);
        $display("add %0d start %0d tick %0d yield %0d sleep %0d until %0d kill %0d query %0d",
                 sb.cmd_count[tps_pkg::CMD_ADD], sb.cmd_count[tps_pkg::CMD_START],
                 sb.cmd_count[tps_pkg::CMD_TICK], sb.cmd_count[tps_pkg::CMD_YIELD],
                 sb.cmd_count[tps_pkg::CMD_SLEEP], sb.cmd_count[tps_pkg::CMD_SLEEP_UNTIL],
                 sb.cmd_count[tps_pkg::CMD_KILL], sb.cmd_count[tps_pkg::CMD_QUERY]);
        $display("%0d decisions compared, %0d rejected, final tick %0d, %0d config writes",
                 sb.decisions_seen, sb.rejected, sb.ticks, cfg_writes);
        if (sb.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
